[rtl/core/double_space_press_detector_assert.svh]
// Assertion macros for the double space press detector.
// Depends on clk_i and rst_ni being visible in the module that includes it.
`ifndef DOUBLE_SPACE_PRESS_DETECTOR_ASSERT_SVH
`define DOUBLE_SPACE_PRESS_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dspd assertion failed");

// Next-cycle implication, checked outside reset.
`define DSPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dspd assertion failed");

`endif

[rtl/core/dspd_pkg.sv]
// Shared types, constants and helpers for the double space press detector.
// No dependencies.
package dspd_pkg;

  localparam int KEY_W    = 8;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;

  localparam logic [CFG_W-1:0] WINDOW_RST = 16'd400;
  localparam logic [CFG_W-1:0] STUCK_RST  = 16'd2000;
  localparam logic [CFG_W-1:0] GUARD_RST  = 16'd1200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgEnable   = 3'd0,
    CfgDsMode   = 3'd1,
    CfgWindow   = 3'd2,
    CfgStuck    = 3'd3,
    CfgGuard    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIgnored    = 3'd0,
    StTextKey    = 3'd1,
    StReleased   = 3'd2,
    StRepeat     = 3'd3,
    StSuppressed = 3'd4,
    StArmed      = 3'd5,
    StTriggered  = 3'd6,
    StRearmed    = 3'd7
  } status_e;

  typedef struct packed {
    logic             enable;
    logic             ds_mode;
    logic [CFG_W-1:0] window;
    logic [CFG_W-1:0] stuck;
    logic [CFG_W-1:0] guard;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_code;
    logic               key_down;
    logic [STAMP_W-1:0] time_ms;
    logic               text_input_active;
  } evt_t;

  typedef struct packed {
    logic    trigger;
    status_e status;
    logic    stuck_cleared;
  } res_t;

  // Letters, digits, keypad digits and punctuation codes.
  function automatic logic is_text_key(input logic [KEY_W-1:0] k);
    return k inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h60:8'h69],
                     [8'hBA:8'hC0], [8'hDB:8'hE2]};
  endfunction

endpackage

[rtl/core/dspd_if.sv]
// Handshake channels of the double space press detector: key events in, results out.
// Depends on dspd_pkg.
interface dspd_evt_if
  import dspd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_code;
  logic               key_down;
  logic [STAMP_W-1:0] time_ms;
  logic               text_input_active;

  modport source (output valid, key_code, key_down, time_ms, text_input_active,
                  input ready);
  modport sink   (input valid, key_code, key_down, time_ms, text_input_active,
                  output ready);
endinterface

interface dspd_res_if;
  logic       valid;
  logic       ready;
  logic       trigger;
  logic [2:0] status;
  logic       stuck_cleared;

  modport source (output valid, trigger, status, stuck_cleared, input ready);
  modport sink   (input valid, trigger, status, stuck_cleared, output ready);
endinterface

[rtl/core/dspd_cfg.sv]
// Configuration register bank of the double space press detector.
// Depends on dspd_pkg.
module dspd_cfg
  import dspd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [CFG_W-1:0]     wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b1, ds_mode: 1'b1, window: WINDOW_RST,
                 stuck: STUCK_RST, guard: GUARD_RST};
    end else if (we_i) begin
      case (idx_i)
        CfgEnable: cfg_q.enable  <= wdata_i[0];
        CfgDsMode: cfg_q.ds_mode <= wdata_i[0];
        CfgWindow: cfg_q.window  <= wdata_i;
        CfgStuck:  cfg_q.stuck   <= wdata_i;
        CfgGuard:  cfg_q.guard   <= wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/dspd_in_stage.sv]
// Input register of the double space press detector.
// Depends on dspd_pkg and dspd_evt_if.
module dspd_in_stage
  import dspd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dspd_evt_if.sink    evt,
  input  logic        take_i,
  output logic        vld_o,
  output evt_t        item_o
);

  logic vld_q;
  evt_t item_q;

  assign evt.ready = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (evt.ready) begin
      vld_q <= evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.ready && evt.valid) begin
      item_q <= '{key_code: evt.key_code, key_down: evt.key_down,
                  time_ms: evt.time_ms, text_input_active: evt.text_input_active};
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/core/dspd_eval.sv]
// Detector state and per-event decision logic.
// Depends on dspd_pkg.
module dspd_eval
  import dspd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic take_i,
  input  evt_t item_i,
  output res_t res_o
);

  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] el_press, el_text, el_rel;
  logic                 hold_fresh, in_guard, in_window;

  logic                 held_q, held_d;
  logic                 first_q, first_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic [TIME_BITS-1:0] rel_q, rel_d;
  logic [TIME_BITS-1:0] text_q, text_d;

  // Timestamps wrap modulo 2^TIME_BITS.
  assign now_wide = 64'(item_i.time_ms);
  assign now      = now_wide[TIME_BITS-1:0];

  assign el_press = now - press_q;
  assign el_text  = now - text_q;
  assign el_rel   = now - rel_q;

  assign hold_fresh = 64'(el_press) <= 64'(cfg_i.stuck);
  assign in_guard   = (text_q != '0) && (64'(el_text) <= 64'(cfg_i.guard));
  assign in_window  = (rel_q != '0) && (64'(el_rel) <= 64'(cfg_i.window));

  always_comb begin
    res_o   = '{trigger: 1'b0, status: StIgnored, stuck_cleared: 1'b0};
    held_d  = held_q;
    first_d = first_q;
    press_d = press_q;
    rel_d   = rel_q;
    text_d  = text_q;
    if (cfg_i.enable && cfg_i.ds_mode) begin
      if (item_i.key_code != KEY_SPACE) begin
        if (item_i.key_down && is_text_key(item_i.key_code)) begin
          text_d       = now;
          res_o.status = StTextKey;
        end
      end else if (!item_i.key_down) begin
        held_d       = 1'b0;
        rel_d        = now;
        res_o.status = StReleased;
      end else if (held_q && hold_fresh) begin
        res_o.status = StRepeat;
      end else begin
        res_o.stuck_cleared = held_q;
        press_d = now;
        held_d  = 1'b1;
        rel_d   = '0;
        if (in_guard || item_i.text_input_active) begin
          first_d      = 1'b0;
          res_o.status = StSuppressed;
        end else if (!first_q) begin
          first_d      = 1'b1;
          res_o.status = StArmed;
        end else if (in_window) begin
          first_d       = 1'b0;
          res_o.trigger = 1'b1;
          res_o.status  = StTriggered;
        end else begin
          first_d      = 1'b1;
          res_o.status = StRearmed;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      first_q <= 1'b0;
      press_q <= '0;
      rel_q   <= '0;
      text_q  <= '0;
    end else if (take_i) begin
      held_q  <= held_d;
      first_q <= first_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      text_q  <= text_d;
    end
  end

endmodule

[rtl/core/dspd_out_stage.sv]
// Result register of the double space press detector.
// Depends on dspd_pkg and dspd_res_if.
module dspd_out_stage
  import dspd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_t      res_i,
  output logic      free_o,
  dspd_res_if.source res
);

  logic vld_q;
  res_t res_q;

  assign free_o = !vld_q || res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res.valid         = vld_q;
  assign res.trigger       = res_q.trigger;
  assign res.status        = res_q.status;
  assign res.stuck_cleared = res_q.stuck_cleared;

endmodule

[rtl/core/double_space_press_detector.sv]
// Double space press detector: a result passes from its event transfer through the input
// register, then the result register behind the decision logic, before it can transfer.
// Throughput is one event per cycle while the result sink stays ready; the input register
// refills whenever the result register is free or being drained in the same cycle.
// Reset (rst_ni low, asynchronous) empties both registers, clears the detector state
// and loads the configuration defaults: enabled, double-space mode, 400/2000/1200 ms.
`include "double_space_press_detector_assert.svh"

module double_space_press_detector
  import dspd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dspd_evt_if.sink             evt_i,
  dspd_res_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t cfg;
  evt_t item;
  res_t res;
  logic in_vld;
  logic out_free;
  logic take;

  // Register bank; to be written only while the pipeline is empty, which the block itself does not enforce.
  dspd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Hold the transferred event until the result register can take its outcome.
  dspd_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt    (evt_i),
    .take_i (take),
    .vld_o  (in_vld),
    .item_o (item)
  );

  // Advance an event out of the input register only when its result has a slot.
  assign take = in_vld && out_free;

  // Decide the outcome and advance the detector state in the same cycle.
  dspd_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .take_i (take),
    .item_i (item),
    .res_o  (res)
  );

  // Present the result until the sink completes the transfer.
  dspd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take),
    .res_i  (res),
    .free_o (out_free),
    .res    (res_o)
  );

  // A trigger only ever comes with the triggered status.
  `DSPD_ASSERT_NOW(a_trig_status, res_o.valid && res_o.trigger, res_o.status == StTriggered)
  // A cleared hold only happens on a press that went on as a fresh press.
  `DSPD_ASSERT_NOW(a_stuck_fresh, res_o.valid && res_o.stuck_cleared,
                   res_o.status == StSuppressed || res_o.status == StArmed ||
                   res_o.status == StTriggered || res_o.status == StRearmed)
  // An event moved out of the input register shows up as a result next cycle.
  `DSPD_ASSERT_NEXT(a_take_result, take, res_o.valid)
  // Never accept a new event over one that is still waiting.
  `DSPD_ASSERT_NOW(a_no_overrun, evt_i.valid && evt_i.ready, !in_vld || take)

endmodule

[bench/tb_double_space_press_detector.sv]
`timescale 1ns / 100ps
// Self-checking bench for double_space_press_detector: timestamped key events go in over
// the event channel, a local predictor of the detector works out each result.
// Depends on dspd_pkg, the channel interfaces in dspd_if.sv and the detector RTL.
module tb_double_space_press_detector;
  import dspd_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int PHASE_COUNT      = 6;
  localparam int EVENT_GOAL       = 1400;
  localparam int SHOWN_MISMATCHES = 10;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  dspd_evt_if evt_ch ();
  dspd_res_if res_ch ();

  double_space_press_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Local copy of the register file and of the detector state.
  cfg_t               cfg_model;
  logic               space_is_down;
  logic [STAMP_W-1:0] press_stamp;
  logic [STAMP_W-1:0] release_stamp;   // zero reads as "no release on record"
  logic [STAMP_W-1:0] text_stamp;      // zero reads as "no text key on record"
  logic               first_tap_seen;

  // Results owed by the detector, oldest first.
  res_t owed_results[$];

  // Running key clock for the generated event stream.
  logic [STAMP_W-1:0] clock_ms;

  // Idling switches: sender gaps per sequence, receiver stalls in stretches.
  logic src_gaps   = 1'b0;
  logic sink_stalls = 1'b0;
  int   stall_left = 0;

  int err_cnt     = 0;
  int checked_cnt = 0;
  int sent_cnt    = 0;
  int acted_cnt   = 0;
  int trig_cnt    = 0;
  int clear_cnt   = 0;
  int cfg_cnt     = 0;

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= SHOWN_MISMATCHES) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Work out the result of one key event and advance the local detector state.
  function automatic res_t detect_double_press(input evt_t ev);
    res_t               r;
    logic               is_text;
    logic [STAMP_W-1:0] since_press;
    logic [STAMP_W-1:0] since_release;
    logic [STAMP_W-1:0] since_text;
    r.trigger       = 1'b0;
    r.status        = StIgnored;
    r.stuck_cleared = 1'b0;
    is_text = (ev.key_code >= 8'h30 && ev.key_code <= 8'h39) ||
              (ev.key_code >= 8'h41 && ev.key_code <= 8'h5A) ||
              (ev.key_code >= 8'h60 && ev.key_code <= 8'h69) ||
              (ev.key_code >= 8'hBA && ev.key_code <= 8'hC0) ||
              (ev.key_code >= 8'hDB && ev.key_code <= 8'hE2);
    // Differences wrap with the 32-bit millisecond counter.
    since_press   = ev.time_ms - press_stamp;
    since_release = ev.time_ms - release_stamp;
    since_text    = ev.time_ms - text_stamp;
    if (cfg_model.enable && cfg_model.ds_mode) begin
      if (ev.key_code != KEY_SPACE) begin
        if (ev.key_down && is_text) begin
          text_stamp = ev.time_ms;
          r.status   = StTextKey;
        end
      end else if (!ev.key_down) begin
        space_is_down = 1'b0;
        release_stamp = ev.time_ms;
        r.status      = StReleased;
      end else if (space_is_down && since_press <= STAMP_W'(cfg_model.stuck)) begin
        r.status = StRepeat;
      end else begin
        // A hold beyond the stuck timeout lost its release: drop it, treat as fresh.
        if (space_is_down) r.stuck_cleared = 1'b1;
        press_stamp   = ev.time_ms;
        space_is_down = 1'b1;
        if ((text_stamp != '0 && since_text <= STAMP_W'(cfg_model.guard)) ||
            ev.text_input_active) begin
          first_tap_seen = 1'b0;
          release_stamp  = '0;
          r.status       = StSuppressed;
        end else if (!first_tap_seen) begin
          first_tap_seen = 1'b1;
          release_stamp  = '0;
          r.status       = StArmed;
        end else if (release_stamp != '0 &&
                     since_release <= STAMP_W'(cfg_model.window)) begin
          first_tap_seen = 1'b0;
          release_stamp  = '0;
          r.trigger      = 1'b1;
          r.status       = StTriggered;
        end else begin
          first_tap_seen = 1'b1;
          release_stamp  = '0;
          r.status       = StRearmed;
        end
      end
    end
    return r;
  endfunction

  // Offer one key event, hold it until the transfer, then log what it must produce.
  // Returns at the edge of the transfer with valid still high; the next call either
  // replaces the payload or drops valid in that same step.
  task automatic send_key(input logic [KEY_W-1:0] key, input logic down,
                          input logic [STAMP_W-1:0] stamp, input logic txt);
    int   gap;
    evt_t ev;
    res_t want;
    gap = 0;
    if (src_gaps && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_ch.valid             <= 1'b1;
    evt_ch.key_code          <= key;
    evt_ch.key_down          <= down;
    evt_ch.time_ms           <= stamp;
    evt_ch.text_input_active <= txt;
    do @(posedge clk_i); while (!evt_ch.ready);
    ev.key_code          = key;
    ev.key_down          = down;
    ev.time_ms           = stamp;
    ev.text_input_active = txt;
    want = detect_double_press(ev);
    owed_results = {owed_results, want};
    sent_cnt++;
    if (want.status != StIgnored) acted_cnt++;
    if (want.trigger) trig_cnt++;
    if (want.stuck_cleared) clear_cnt++;
  endtask

  // Space event a given number of milliseconds after the previous one.
  task automatic space_after(input logic down, input logic [STAMP_W-1:0] delta,
                             input logic txt);
    clock_ms = clock_ms + delta;
    send_key(KEY_SPACE, down, clock_ms, txt);
  endtask

  // Drop valid and wait until every owed result has been taken, plus a margin.
  task automatic settle();
    evt_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all five registers back to back while the detector is idle.
  task automatic set_config(input cfg_t c);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgEnable;
    cfg_wdata_i <= CFG_W'(c.enable);
    @(posedge clk_i);
    cfg_idx_i   <= CfgDsMode;
    cfg_wdata_i <= CFG_W'(c.ds_mode);
    @(posedge clk_i);
    cfg_idx_i   <= CfgWindow;
    cfg_wdata_i <= c.window;
    @(posedge clk_i);
    cfg_idx_i   <= CfgStuck;
    cfg_wdata_i <= c.stuck;
    @(posedge clk_i);
    cfg_idx_i   <= CfgGuard;
    cfg_wdata_i <= c.guard;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_model = c;
    cfg_cnt++;
    repeat (2) @(posedge clk_i);
  endtask

  // Delay that lands on, just either side of, below, well past or far beyond a limit.
  function automatic logic [STAMP_W-1:0] around_limit(input logic [CFG_W-1:0] limit);
    int unsigned        pick;
    logic [STAMP_W-1:0] base;
    pick = $urandom_range(0, 9);
    base = STAMP_W'(limit);
    if (pick < 6) begin
      base = base + $urandom_range(0, 6);
      return (base < 3) ? '0 : base - 3;
    end
    if (pick < 8) return $urandom_range(0, limit);
    if (pick == 8) return base + $urandom_range(0, 3000);
    return $urandom();
  endfunction

  function automatic logic [KEY_W-1:0] any_text_key();
    case ($urandom_range(0, 4))
      0:       return KEY_W'($urandom_range(8'h30, 8'h39));
      1:       return KEY_W'($urandom_range(8'h41, 8'h5A));
      2:       return KEY_W'($urandom_range(8'h60, 8'h69));
      3:       return KEY_W'($urandom_range(8'hBA, 8'hC0));
      default: return KEY_W'($urandom_range(8'hDB, 8'hE2));
    endcase
  endfunction

  // Result side: check every transfer against the oldest owed result, then pick
  // the next ready level. Stalls come in stretches, with stall-free stretches between.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        checked_cnt++;
        if (owed_results.size() == 0) begin
          note_error($sformatf("result %0d with nothing owed: trigger %0b status %0d stuck %0b",
                               checked_cnt, res_ch.trigger, res_ch.status,
                               res_ch.stuck_cleared));
        end else begin
          want = owed_results.pop_front();
          if (res_ch.trigger !== want.trigger || res_ch.status !== want.status ||
              res_ch.stuck_cleared !== want.stuck_cleared)
            note_error($sformatf({"result %0d: expected trigger %0b status %0d stuck %0b,",
                                  " got trigger %0b status %0d stuck %0b"},
                                 checked_cnt, want.trigger, want.status,
                                 want.stuck_cleared, res_ch.trigger, res_ch.status,
                                 res_ch.stuck_cleared));
        end
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!sink_stalls || $urandom_range(0, 99) < 75) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
      end
      if ($urandom_range(0, 199) == 0) sink_stalls = !sink_stalls;
    end
  end

  // Hand-picked events under the reset configuration: every status, both sides of the
  // window and stuck limits, the guard limit, zero stamps, counter wrap and text key edges.
  task automatic test_directed();
    space_after(1'b1, 32'd1000, 1'b0);          // first press arms
    space_after(1'b0, 32'd100,  1'b0);
    space_after(1'b1, 32'd400,  1'b0);          // gap equal to the window fires
    space_after(1'b1, 32'd100,  1'b0);          // auto-repeat
    space_after(1'b0, 32'd100,  1'b0);
    space_after(1'b1, 32'd100,  1'b0);          // arms again after a trigger
    space_after(1'b0, 32'd100,  1'b0);
    space_after(1'b1, 32'd401,  1'b0);          // one past the window: rearm
    space_after(1'b1, 32'd2000, 1'b0);          // hold equal to the timeout: still repeat
    space_after(1'b1, 32'd1,    1'b0);          // one past: clear the stuck hold
    clock_ms = 32'd5000;
    send_key(8'h41, 1'b1, clock_ms, 1'b0);      // text key noted
    space_after(1'b0, 32'd100,  1'b0);
    space_after(1'b1, 32'd1100, 1'b0);          // exactly at the guard: suppressed
    space_after(1'b0, 32'd100,  1'b0);
    space_after(1'b1, 32'd1700, 1'b1);          // text entry active: suppressed
    send_key(8'h41, 1'b0, clock_ms, 1'b0);      // text key release: ignored
    send_key(8'h00, 1'b1, clock_ms, 1'b1);
    send_key(8'hFF, 1'b1, clock_ms, 1'b0);
    send_key(8'h2F, 1'b1, clock_ms, 1'b0);
    send_key(8'hE3, 1'b1, clock_ms, 1'b0);
    send_key(8'h30, 1'b1, clock_ms, 1'b0);
    send_key(8'hE2, 1'b1, clock_ms, 1'b0);
    // Zero stamps store as unset: neither the guard nor the window sees them.
    send_key(KEY_SPACE, 1'b0, 32'd0, 1'b0);
    send_key(8'h41, 1'b1, 32'd0, 1'b0);
    send_key(KEY_SPACE, 1'b1, 32'd100, 1'b0);
    // Release just before the counter wraps, press just after it.
    send_key(KEY_SPACE, 1'b0, 32'hFFFF_FF00, 1'b0);
    send_key(KEY_SPACE, 1'b1, 32'h0000_0010, 1'b0);
    send_key(KEY_SPACE, 1'b1, 32'hFFFF_FFFF, 1'b1);
    clock_ms = 32'd20000;
  endtask

  // Disabled and custom hotkey mode: every event is ignored and leaves state alone.
  task automatic test_inactive_modes();
    set_config('{1'b0, 1'b1, WINDOW_RST, STUCK_RST, GUARD_RST});
    space_after(1'b1, 32'd50, 1'b0);
    space_after(1'b0, 32'd50, 1'b0);
    send_key(8'h5A, 1'b1, clock_ms, 1'b0);
    space_after(1'b1, 32'd50, 1'b1);
    set_config('{1'b1, 1'b0, WINDOW_RST, STUCK_RST, GUARD_RST});
    space_after(1'b1, 32'd50, 1'b0);
    space_after(1'b0, 32'd50, 1'b0);
    send_key(8'h60, 1'b1, clock_ms, 1'b0);
    space_after(1'b1, 32'd50, 1'b1);
  endtask

  // Random well-formed sequences with some noise, until enough events have been acted on.
  task automatic run_phase(input int goal);
    int          stop_at;
    int          n;
    logic        txt;
    logic [31:0] stamp;
    stop_at = acted_cnt + goal;
    while (acted_cnt < stop_at) begin
      src_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin     // double tap, second press around the window
          space_after(1'b1, $urandom_range(0, 3000), $urandom_range(0, 19) == 0);
          space_after(1'b0, $urandom_range(0, 300), 1'b0);
          space_after(1'b1, around_limit(cfg_model.window), $urandom_range(0, 19) == 0);
          space_after(1'b0, $urandom_range(0, 300), 1'b0);
        end
        4: begin              // held key with auto-repeat
          space_after(1'b1, $urandom_range(0, 3000), 1'b0);
          n = $urandom_range(1, 5);
          repeat (n)
            space_after(1'b1, ($urandom_range(0, 3) == 0) ? around_limit(cfg_model.stuck)
                                                         : $urandom_range(0, 60), 1'b0);
          space_after(1'b0, $urandom_range(0, 300), 1'b0);
        end
        5: begin              // release lost: next press around the stuck timeout
          space_after(1'b1, $urandom_range(0, 3000), 1'b0);
          space_after(1'b1, around_limit(cfg_model.stuck), $urandom_range(0, 9) == 0);
          if ($urandom_range(0, 1)) space_after(1'b0, $urandom_range(0, 300), 1'b0);
        end
        6, 7: begin           // typing, then space around the guard time
          clock_ms = clock_ms + $urandom_range(0, 500);
          send_key(any_text_key(), 1'b1, clock_ms, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1)) begin
            clock_ms = clock_ms + $urandom_range(0, 100);
            send_key(any_text_key(), 1'b0, clock_ms, 1'b0);
          end
          space_after(1'b1, around_limit(cfg_model.guard), $urandom_range(0, 9) == 0);
          space_after(1'b0, $urandom_range(0, 300), 1'b0);
        end
        8: begin              // jump the clock: zero, near the wrap, or anywhere
          case ($urandom_range(0, 2))
            0:       clock_ms = '0;
            1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            default: clock_ms = $urandom();
          endcase
          case ($urandom_range(0, 2))
            0:       send_key(KEY_SPACE, 1'b0, clock_ms, 1'b0);
            1:       send_key(any_text_key(), 1'b1, clock_ms, 1'b0);
            default: send_key(KEY_SPACE, 1'b1, clock_ms, 1'b0);
          endcase
        end
        default: begin        // noise: any key, any direction, any stamp
          n = $urandom_range(1, 4);
          repeat (n) begin
            stamp = ($urandom_range(0, 4) == 0) ? $urandom()
                                                : clock_ms + $urandom_range(0, 2000);
            clock_ms = stamp;
            txt = 1'($urandom_range(0, 1));
            send_key(($urandom_range(0, 2) == 0) ? KEY_SPACE : KEY_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), stamp, txt);
          end
        end
      endcase
    end
  endtask

  // Sweep the register settings, extremes included, with a random run under each.
  task automatic test_random_settings();
    int per_phase;
    per_phase = EVENT_GOAL / PHASE_COUNT;
    set_config('{1'b1, 1'b1, WINDOW_RST, STUCK_RST, GUARD_RST});
    run_phase(per_phase);
    set_config('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0});
    run_phase(per_phase);
    set_config('{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_phase(per_phase);
    set_config('{1'b1, 1'b1, CFG_W'($urandom_range(1, 1000)),
                 CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 2000))});
    run_phase(per_phase);
    set_config('{1'b1, 1'b1, CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom())});
    run_phase(per_phase);
    set_config('{1'b1, 1'b1, 16'hFFFF, 16'd1, 16'd0});
    run_phase(per_phase);
  endtask

  initial begin
    evt_ch.valid             = 1'b0;
    evt_ch.key_code          = '0;
    evt_ch.key_down          = 1'b0;
    evt_ch.time_ms           = '0;
    evt_ch.text_input_active = 1'b0;
    res_ch.ready             = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = CfgEnable;
    cfg_wdata_i              = '0;
    // Reset values of the registers and the detector state.
    cfg_model      = '{1'b1, 1'b1, WINDOW_RST, STUCK_RST, GUARD_RST};
    space_is_down  = 1'b0;
    press_stamp    = '0;
    release_stamp  = '0;
    text_stamp     = '0;
    first_tap_seen = 1'b0;
    clock_ms       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_inactive_modes();
    test_random_settings();

    settle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d key events (%0d acted on) under %0d register settings.",
             sent_cnt, acted_cnt, cfg_cnt);
    $display("Checked %0d results: %0d triggers, %0d stuck holds cleared.",
             checked_cnt, trig_cnt, clear_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results still owed", owed_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dspd_pkg.sv
rtl/core/dspd_if.sv
rtl/core/dspd_cfg.sv
rtl/core/dspd_in_stage.sv
rtl/core/dspd_eval.sv
rtl/core/dspd_out_stage.sv
rtl/core/double_space_press_detector.sv
bench/tb_double_space_press_detector.sv
